// ----- hw/rtl/lbb_pkg.sv -----
// shared types, codes and helpers for the led blink/burst/breathe block
`timescale 1ns / 1ps

package lbb_pkg;

  localparam int TIME_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ON_TIME     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF_TIME    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REST_TIME   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BLINK_COUNT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE        = 3'd5;

  // mode codes
  localparam logic [2:0] MODE_HOLD  = 3'd0;
  localparam logic [2:0] MODE_ON    = 3'd1;
  localparam logic [2:0] MODE_OFF   = 3'd2;
  localparam logic [2:0] MODE_BURST = 3'd3;
  localparam logic [2:0] MODE_PULSE = 3'd4;

  localparam logic [23:0] COLOR_RST       = 24'h0000FF;
  localparam logic [7:0]  BLINK_COUNT_RST = 8'd1;

  typedef struct packed {
    logic [23:0] color;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [15:0] rest_time;
    logic [7:0]  blink_count;
    logic [2:0]  mode;
  } cfg_t;

  typedef struct packed {
    logic [23:0] pixel;
    logic        show;
    logic        lit;
  } result_t;

  // floor(ch * (255 - level) / 255), exact for the 16-bit product range
  function automatic logic [7:0] dim_channel(input logic [7:0] ch, input logic [7:0] level);
    logic [15:0] prod;
    logic [16:0] acc;
    prod = 16'(ch) * (16'd255 - 16'(level));
    acc  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
    return acc[15:8];
  endfunction

endpackage

// ----- hw/rtl/lbb_cfg.sv -----
// configuration register file, write only
`timescale 1ns / 1ps

module lbb_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lbb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lbb_pkg::cfg_t                 cfg,
  output logic                          mode_wr
);
  import lbb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color       <= COLOR_RST;
      cfg.on_time     <= '0;
      cfg.off_time    <= '0;
      cfg.rest_time   <= '0;
      cfg.blink_count <= BLINK_COUNT_RST;
      cfg.mode        <= MODE_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COLOR:       cfg.color       <= cfg_wdata;
        REG_ON_TIME:     cfg.on_time     <= cfg_wdata[15:0];
        REG_OFF_TIME:    cfg.off_time    <= cfg_wdata[15:0];
        REG_REST_TIME:   cfg.rest_time   <= cfg_wdata[15:0];
        REG_BLINK_COUNT: cfg.blink_count <= cfg_wdata[7:0];
        REG_MODE:        cfg.mode        <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // mode write restarts the burst and the wait
  assign mode_wr = cfg_we && (cfg_addr == REG_MODE);

endmodule

// ----- hw/rtl/lbb_core.sv -----
// pattern state and one-tick update logic
`timescale 1ns / 1ps

module lbb_core #(
  parameter int TIME_BITS = lbb_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lbb_pkg::cfg_t    cfg,
  input  logic             mode_wr,
  input  logic             step_en,
  input  logic             tick,
  output lbb_pkg::result_t res
);
  import lbb_pkg::*;

  localparam logic [31:0] TimeMax = 32'((64'd1 << TIME_BITS) - 64'd1);

  logic [TIME_BITS-1:0] wait_left, wait_left_next, wait_dec;
  logic [7:0]           blinks_left, blinks_left_next;
  logic                 led_lit, led_lit_next;
  logic [7:0]           fade_level, fade_level_next;
  logic                 fade_up, fade_up_next;
  logic [23:0]          pixel_out, pixel_out_next;
  logic                 show;

  // saturate to the counter range, never below one
  function automatic logic [TIME_BITS-1:0] load_wait(input logic [15:0] w);
    logic [31:0] v;
    v = {16'd0, w};
    if (v > TimeMax) v = TimeMax;
    if (v == 32'd0) v = 32'd1;
    return v[TIME_BITS-1:0];
  endfunction

  assign wait_dec = (wait_left != '0) ? wait_left - TIME_BITS'(1) : wait_left;

  always_comb begin
    wait_left_next   = wait_left;
    blinks_left_next = blinks_left;
    led_lit_next     = led_lit;
    fade_level_next  = fade_level;
    fade_up_next     = fade_up;
    pixel_out_next   = pixel_out;
    show             = 1'b0;
    if (tick) begin
      case (cfg.mode)
        MODE_ON: begin
          pixel_out_next = cfg.color;
          led_lit_next   = 1'b1;
          show           = 1'b1;
        end
        MODE_OFF: begin
          pixel_out_next = '0;
          led_lit_next   = 1'b0;
          show           = 1'b1;
        end
        MODE_BURST: begin
          wait_left_next = wait_dec;
          if (wait_dec == '0) begin
            show = 1'b1;
            if (!led_lit) begin
              pixel_out_next   = cfg.color;
              wait_left_next   = load_wait(cfg.on_time);
              blinks_left_next = blinks_left - 8'd1;
              led_lit_next     = 1'b1;
            end else begin
              pixel_out_next = '0;
              led_lit_next   = 1'b0;
              if (blinks_left != 8'd0) begin
                wait_left_next = load_wait(cfg.off_time);
              end else begin
                wait_left_next   = load_wait(cfg.rest_time);
                blinks_left_next = cfg.blink_count;
              end
            end
          end
        end
        MODE_PULSE: begin
          wait_left_next = wait_dec;
          if (wait_dec == '0) begin
            show = 1'b1;
            pixel_out_next = {dim_channel(cfg.color[23:16], fade_level),
                              dim_channel(cfg.color[15:8], fade_level),
                              dim_channel(cfg.color[7:0], fade_level)};
            if (fade_up) begin
              if (fade_level != 8'd255) fade_level_next = fade_level + 8'd1;
            end else begin
              if (fade_level != 8'd0) fade_level_next = fade_level - 8'd1;
            end
            if (fade_level_next <= 8'd1) fade_up_next = 1'b1;
            else if (fade_level_next == 8'd255) fade_up_next = 1'b0;
            wait_left_next = load_wait(cfg.rest_time);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_left   <= '0;
      blinks_left <= 8'd1;
      led_lit     <= 1'b0;
      fade_level  <= '0;
      fade_up     <= 1'b1;
      pixel_out   <= '0;
    end else if (mode_wr) begin
      wait_left   <= '0;
      blinks_left <= cfg.blink_count;
    end else if (step_en) begin
      wait_left   <= wait_left_next;
      blinks_left <= blinks_left_next;
      led_lit     <= led_lit_next;
      fade_level  <= fade_level_next;
      fade_up     <= fade_up_next;
      pixel_out   <= pixel_out_next;
    end
  end

  assign res.pixel = pixel_out_next;
  assign res.show  = show;
  assign res.lit   = led_lit_next;

endmodule

// ----- hw/rtl/led_blink_burst_and_breathe.sv -----
// top level: stream ports, input and result registers, config and pattern core
`timescale 1ns / 1ps

// Drives one RGB pixel from millisecond tick items. Each item on the slave
// stream carries one tick bit; each produces exactly one result item with the
// current red, green, blue, a show flag (pixel refreshed by this tick) and the
// lit flag. Modes: hold, steady on, steady off, burst blink (on_time lit,
// off_time dark between blinks, rest_time dark after blink_count blinks) and
// pulse (triangle fade stepped every rest_time ticks). A wait of w ticks
// lasts max(w,1) ticks, capped at 2^TIME_BITS-1. Writing the mode register
// restarts the burst so the next tick steps at once. Rate: one item per
// cycle while m_tready is held high; an item is held in the input register,
// its result is computed by the pattern core (one 8x8 multiply per channel)
// and is registered in the result register once the result slot is free.
// The user must write configuration only while the block is idle; the block
// itself does not enforce this. No clearing pass after reset.
module led_blink_burst_and_breathe #(
  parameter int TIME_BITS = lbb_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [0] tick, [7:1] zero
  // master stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // [7:0] red, [15:8] green,
                                                    // [23:16] blue, [24] show,
                                                    // [25] lit, [31:26] zero
  // configuration write port
  input  logic                           cfg_we,
  input  logic [lbb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lbb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lbb_pkg::*;

  cfg_t    cfg;
  logic    mode_wr;
  result_t res;

  // input register
  logic    in_valid;
  logic    in_tick;
  // result register
  logic    out_valid;
  result_t out_res;

  logic    advance;

  // move an item from input to result register when the result slot frees
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  lbb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .mode_wr   (mode_wr)
  );

  lbb_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .mode_wr (mode_wr),
    .step_en (advance),
    .tick    (in_tick),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tick <= s_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.lit, out_res.show, out_res.pixel[7:0],
                     out_res.pixel[15:8], out_res.pixel[23:16]};

`ifndef SYNTH
  // input side stalls only behind a full result register
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a pending result");

  // an item with no tick never refreshes the pixel
  a_no_tick_no_show: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_tick) |=> !out_res.show)
    else $error("show raised without a tick");

  // steady off gives black, shown, unlit
  a_steady_off: assert property (@(posedge clk) disable iff (rst)
    (advance && in_tick && cfg.mode == MODE_OFF)
      |=> (out_res.show && !out_res.lit && out_res.pixel == 24'd0))
    else $error("steady off result wrong");

  // hold mode refreshes nothing
  a_hold_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && cfg.mode == MODE_HOLD) |=> !out_res.show)
    else $error("hold mode refreshed the pixel");
`endif

endmodule
